@@ design/assert_macros.svh @@
// Assertion macros used by the checker module clt_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle check");

`endif

@@ design/clt_pkg.sv @@
// ----------------------------------------------------------------------------
// clt_pkg
// Types, character codes and helper functions shared by the tokenizer files.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Width of the internal byte counter and of the emitted start offset.
  localparam int POS_W   = 24;
  localparam int START_W = 24;
  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 4;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_SLASH   = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_STRING  = 3'd4,
    MODE_HALTED  = 3'd5
  } mode_t;

  // Token kinds.
  typedef enum logic [3:0] {
    KIND_IDENT        = 4'd0,
    KIND_STRING       = 4'd1,
    KIND_COLON        = 4'd2,
    KIND_COMMA        = 4'd3,
    KIND_LBRACE       = 4'd4,
    KIND_RBRACE       = 4'd5,
    KIND_LPAREN       = 4'd6,
    KIND_RPAREN       = 4'd7,
    KIND_EOF          = 4'd8,
    KIND_ILLEGAL      = 4'd9,
    KIND_UNTERMINATED = 4'd10
  } kind_t;

  // Character codes.
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;

  // One source byte.
  typedef struct packed {
    logic [7:0] ch;
    logic       last_byte;
  } in_item_t;

  // One token.
  typedef struct packed {
    kind_t              token_kind;
    logic [START_W-1:0] token_start;
    logic               run_last;
  } out_item_t;

  // Tokens produced by one byte, in order, with their count.
  typedef struct packed {
    logic [1:0]                cnt;
    out_item_t [MAX_RES-1:0]   items;
  } push_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic starts_ident(input logic [7:0] c);
    return is_letter(c) || c == CH_DASH || c == CH_DOT;
  endfunction

  function automatic logic continues_ident(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDERSCORE ||
           c == CH_SLASH || c == CH_DOT || c == CH_DASH;
  endfunction

  // Map a byte offset onto the fixed-width start field.
  function automatic logic [START_W-1:0] to_start(input logic [POS_W-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[START_W-1:0];
  endfunction

endpackage

@@ design/clt_scan.sv @@
// ----------------------------------------------------------------------------
// clt_scan
// Scanner state and the per-byte token logic; yields up to three tokens a byte.
// ----------------------------------------------------------------------------
module clt_scan
  import clt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  in_item_t in_data,
  output push_t    push
);

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] tb_r, tb_nxt;

  // Candidate tokens: a closed identifier, a middle token, the end token.
  out_item_t [2:0]  cand;
  logic [2:0]       cand_v;

  // Per-byte decision.
  always_comb begin
    logic [7:0]       c;
    logic             fresh;
    mode_t            m1;
    logic [POS_W-1:0] tb1;
    logic [POS_W-1:0] pos_inc;
    logic             stop;

    c       = in_data.ch;
    fresh   = 1'b0;
    m1      = mode_r;
    tb1     = tb_r;
    pos_inc = pos_r + 1'b1;
    stop    = 1'b0;
    cand_v  = '0;
    cand[0] = '{token_kind: KIND_IDENT, token_start: to_start(tb_r), run_last: 1'b0};
    cand[1] = '{token_kind: KIND_STRING, token_start: to_start(tb_r), run_last: 1'b0};
    cand[2] = '{token_kind: KIND_EOF, token_start: to_start(pos_inc), run_last: 1'b0};

    // Pending token handling.
    unique case (mode_r)
      MODE_IDLE: begin
        fresh = 1'b1;
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          m1 = MODE_COMMENT;
        end else if (continues_ident(c)) begin
          m1 = MODE_IDENT;
        end else begin
          cand_v[0] = 1'b1;
          fresh     = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!continues_ident(c)) begin
          cand_v[0] = 1'b1;
          fresh     = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NEWLINE) begin
          m1 = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          cand_v[1] = 1'b1;
          m1        = MODE_IDLE;
        end
      end
      default: begin
        m1   = MODE_HALTED;
        stop = 1'b1;
      end
    endcase

    // A byte seen with no token pending.
    if (fresh) begin
      m1 = MODE_IDLE;
      cand[1].token_start = to_start(pos_r);
      priority if (c == CH_SLASH) begin
        m1  = MODE_SLASH;
        tb1 = pos_r;
      end else if (starts_ident(c)) begin
        m1  = MODE_IDENT;
        tb1 = pos_r;
      end else if (c == CH_QUOTE) begin
        m1  = MODE_STRING;
        tb1 = pos_r;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) begin
        m1 = MODE_IDLE;
      end else begin
        cand_v[1] = 1'b1;
        unique case (c)
          CH_COLON:  cand[1].token_kind = KIND_COLON;
          CH_COMMA:  cand[1].token_kind = KIND_COMMA;
          CH_LBRACE: cand[1].token_kind = KIND_LBRACE;
          CH_RBRACE: cand[1].token_kind = KIND_RBRACE;
          CH_LPAREN: cand[1].token_kind = KIND_LPAREN;
          CH_RPAREN: cand[1].token_kind = KIND_RPAREN;
          default: begin
            cand[1].token_kind = KIND_ILLEGAL;
            m1 = MODE_HALTED;
          end
        endcase
      end
    end

    // End of file closes what is pending.
    mode_nxt = m1;
    tb_nxt   = tb1;
    pos_nxt  = pos_r;
    if (!stop && m1 != MODE_HALTED) begin
      if (in_data.last_byte) begin
        if (m1 == MODE_IDENT || m1 == MODE_SLASH) begin
          cand_v[1]           = 1'b1;
          cand[1].token_kind  = KIND_IDENT;
          cand[1].token_start = to_start(tb1);
        end else if (m1 == MODE_STRING) begin
          cand_v[1]           = 1'b1;
          cand[1].token_kind  = KIND_UNTERMINATED;
          cand[1].token_start = to_start(tb1);
          mode_nxt            = MODE_HALTED;
        end
        if (m1 != MODE_STRING) begin
          cand_v[2] = 1'b1;
          mode_nxt  = MODE_IDLE;
          pos_nxt   = '0;
          tb_nxt    = '0;
        end
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  // Pack the valid candidates in order and flag the last one.
  always_comb begin
    logic [1:0] n;
    n = '0;
    push.items = '0;
    for (int k = 0; k < 3; k++) begin
      if (cand_v[k]) begin
        push.items[n] = cand[k];
        n = n + 1'b1;
      end
    end
    for (int k = 0; k < MAX_RES; k++) begin
      push.items[k].run_last = (n != 2'd0) && (2'(k) == n - 2'd1);
    end
    push.cnt = n;
  end

  // Scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      tb_r   <= '0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      tb_r   <= tb_nxt;
    end
  end

endmodule

@@ design/clt_queue.sv @@
// ----------------------------------------------------------------------------
// clt_queue
// Four-entry result queue: takes up to three tokens a cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module clt_queue
  import clt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  q_r   [QDEPTH];
  out_item_t  q_nxt [QDEPTH];
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [2:0] base;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[0];
  assign room      = (cnt_r <= 3'd1);
  assign pop       = out_valid && out_ready;

  // Shift out the taken transaction, then append the new tokens.
  always_comb begin
    logic [2:0] slot;
    base = cnt_r - {2'b00, pop};
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[QDEPTH-1] = q_r[QDEPTH-1];
    for (int i = 0; i < QDEPTH; i++) begin
      slot = 3'(i) - base;
      if (push_en && 3'(i) >= base && slot < {1'b0, push.cnt}) begin
        q_nxt[i] = push.items[slot[1:0]];
      end
    end
    cnt_nxt = base + (push_en ? {1'b0, push.cnt} : 3'd0);
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/config_language_tokenizer.sv @@
// ----------------------------------------------------------------------------
// config_language_tokenizer
// Streaming tokenizer for a small configuration language.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one source byte per
//   transaction, with last_byte marking the final byte of a file. The output
//   channel (out_valid/out_ready/out_data) delivers tokens with their start
//   offsets; run_last marks the last token caused by a given byte.
//   A byte's tokens enter the result queue as the byte is accepted and are
//   offered behind any token already waiting. Throughput is one byte per
//   cycle while each byte yields at most one token and the receiver takes
//   each one; the four-entry result queue accepts a byte only while at most
//   one token is waiting, so a byte yielding more tokens holds off the next.
//   When the receiver stalls, tokens wait in the queue and in_ready drops
//   once more than one token is pending. After an illegal byte or an
//   unterminated string, later bytes are accepted but give no tokens.
//   Reset (rst_n low, synchronous) empties the queue and returns the scanner
//   to idle at offset zero.
// ----------------------------------------------------------------------------
module config_language_tokenizer
  import clt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic  accept;
  logic  room;
  push_t push;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  // Per-byte scanner.
  clt_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .in_data (in_data),
    .push    (push)
  );

  // Result queue.
  clt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (accept),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/clt_checker.sv @@
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks of the tokenizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clt_checker
  import clt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic taken;
  logic is_error;

  assign taken    = out_valid && out_ready;
  assign is_error = (out_data.token_kind == KIND_ILLEGAL) ||
                    (out_data.token_kind == KIND_UNTERMINATED);

  // A stalled token stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // The end token always closes the run of its byte.
  `ASSERT_SAME(a_eof_last, clk, rst_n, out_valid && out_data.token_kind == KIND_EOF, out_data.run_last)

  // An error token is the last token of its byte.
  `ASSERT_SAME(a_err_last, clk, rst_n, out_valid && is_error, out_data.run_last)

  // Nothing follows an error token.
  `ASSERT_NEXT(a_err_silent, clk, rst_n, taken && is_error, !out_valid)

endmodule

bind config_language_tokenizer clt_checker u_clt_checker (.*);
